FILE: src/scfr_pkg.sv
// shared types and constants for the sum checked frame receiver
// no dependencies; every other file except scfr_ram refers to this package by scoped names
`default_nettype none

package scfr_pkg;

   // frame store geometry
   localparam int FRAME_BYTES = 64;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

   // field widths
   localparam int BYTE_W   = 8;
   localparam int CTR_W    = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEADER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HEADER = 1'd1;

   // register reset values
   localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET = 8'h55;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_FRAME    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SUM_ERR  = 2'd2;

   typedef enum logic [2:0] {
      F_HEAD1,
      F_HEAD2,
      F_LEN,
      F_PAYLOAD,
      F_CHECK
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_LOAD,
      B_ERROR
   } back_state_type;

   // one entry of work for the back part
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
      logic [CTR_W-1:0]    good;
      logic [CTR_W-1:0]    len_err;
      logic [CTR_W-1:0]    sum_err;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } ram_write_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_read_type;

endpackage

`default_nettype wire

FILE: src/scfr_if.sv
// channel interfaces for the receiver: received bytes, results, register writes
// depends on scfr_pkg
`default_nettype none

interface scfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [scfr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scfr_pkg::BYTE_W-1:0]   frame_byte;
   logic                          last_of_frame;
   logic [scfr_pkg::STATUS_W-1:0] status;
   logic [scfr_pkg::CTR_W-1:0]    good_frames;
   logic [scfr_pkg::CTR_W-1:0]    length_errors;
   logic [scfr_pkg::CTR_W-1:0]    checksum_errors;

   modport source (output valid, output frame_byte, output last_of_frame, output status,
                   output good_frames, output length_errors, output checksum_errors,
                   input ready);
   modport sink (input valid, input frame_byte, input last_of_frame, input status,
                 input good_frames, input length_errors, input checksum_errors,
                 output ready);
endinterface

interface scfr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [scfr_pkg::CSR_IDX_W-1:0] index;
   logic [scfr_pkg::BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sum_checked_frame_receiver.sv
// result path: a checking byte's command is pushed into the queue and popped by the idle back part,
// then frame data passes the store read and load states, and an error status the error state only
// throughput: one received byte per cycle; a verified frame replays each byte through a read state
// then a load state on the frame store port; the length byte of a new frame waits until the
// previous frame has been replayed, and input stalls while the queue is full
// reset: synchronous, clears parser state, counters, queue and result valid; headers 0xAA/0x55
// top level: front parser, command queue, back replay unit and frame store ram
`default_nettype none

module sum_checked_frame_receiver (
   input  wire logic  clock,
   input  wire logic  reset,
   scfr_req_if.sink   req_chan,
   scfr_rsp_if.source rsp_chan,
   scfr_csr_if.sink   csr_chan
);

   scfr_pkg::queue_status_type  q_status;
   scfr_pkg::cmd_type           push_cmd;
   scfr_pkg::cmd_type           head;
   scfr_pkg::ram_write_type     ram_wr;
   scfr_pkg::ram_read_type      ram_rd;
   logic                        push;
   logic                        pop;
   logic                        back_busy;
   logic [scfr_pkg::BYTE_W-1:0] rd_data;

   scfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .q_status  (q_status),
      .back_busy (back_busy),
      .ram_wr    (ram_wr),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   scfr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   scfr_ram #(
      .WIDTH (scfr_pkg::BYTE_W),
      .DEPTH (scfr_pkg::FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (rd_data)
   );

   scfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .busy     (back_busy),
      .ram_rd   (ram_rd),
      .rd_data  (rd_data),
      .rsp_chan (rsp_chan)
   );

   // the store is never filled while a frame is being replayed from it
   a_store_exclusive: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> (!back_busy && !ram_rd.en))
      else $error("frame store written during replay");

   // the front only pushes when the queue has room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command queue overflow");

   // error status results stand alone and carry a zero byte
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != scfr_pkg::STATUS_FRAME) |->
      (rsp_chan.last_of_frame && rsp_chan.frame_byte == '0))
      else $error("error result malformed");

   // a pop only happens on a non-empty queue from an idle back part
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!q_status.empty && !back_busy) ##1 back_busy)
      else $error("back part popped while busy");

endmodule

`default_nettype wire

FILE: src/scfr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module scfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/scfr_front.sv
// front part: header hunt, length check, payload store, checksum compare
// depends on scfr_pkg and scfr_if; writes the frame store and pushes commands
`default_nettype none

module scfr_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   scfr_req_if.sink                        req_chan,
   scfr_csr_if.sink                        csr_chan,
   input  wire scfr_pkg::queue_status_type q_status,
   input  wire logic                       back_busy,
   output scfr_pkg::ram_write_type         ram_wr,
   output logic                            push,
   output scfr_pkg::cmd_type               push_cmd
);

   scfr_pkg::front_state_type state_ff, state_in;
   logic [scfr_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [scfr_pkg::IDX_W-1:0]  plen_ff, plen_in;
   logic [scfr_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [scfr_pkg::CTR_W-1:0]  good_ff, good_in;
   logic [scfr_pkg::CTR_W-1:0]  lerr_ff, lerr_in;
   logic [scfr_pkg::CTR_W-1:0]  serr_ff, serr_in;
   logic [scfr_pkg::BYTE_W-1:0] first_hdr_ff;
   logic [scfr_pkg::BYTE_W-1:0] second_hdr_ff;

   logic                        accept;
   logic [scfr_pkg::BYTE_W-1:0] rx;
   logic                        len_bad;
   logic                        store_full;
   logic                        payload_done;

   // the length byte opens a new frame store fill, so wait until the back part
   // has finished reading the previous one
   assign req_chan.ready = !q_status.full &&
                           !(state_ff == scfr_pkg::F_LEN && (!q_status.empty || back_busy));
   assign accept = req_chan.valid && req_chan.ready;
   assign rx     = req_chan.rx_byte;

   assign len_bad      = (rx == '0) || ({1'b0, rx} >= (scfr_pkg::BYTE_W + 1)'(scfr_pkg::FRAME_BYTES));
   assign store_full   = idx_ff >= scfr_pkg::CNT_W'(scfr_pkg::FRAME_BYTES);
   assign payload_done = idx_ff >= scfr_pkg::CNT_W'(plen_ff);

   assign csr_chan.ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (state_ff)
            scfr_pkg::F_HEAD1: begin
               if (rx == first_hdr_ff) begin
                  state_in = scfr_pkg::F_HEAD2;
               end
            end
            scfr_pkg::F_HEAD2: begin
               state_in = (rx == second_hdr_ff) ? scfr_pkg::F_LEN : scfr_pkg::F_HEAD1;
            end
            scfr_pkg::F_LEN: begin
               state_in = len_bad ? scfr_pkg::F_HEAD1 : scfr_pkg::F_PAYLOAD;
            end
            scfr_pkg::F_PAYLOAD: begin
               if (store_full) begin
                  state_in = scfr_pkg::F_HEAD1;
               end else if (payload_done) begin
                  state_in = scfr_pkg::F_CHECK;
               end
            end
            scfr_pkg::F_CHECK: begin
               state_in = scfr_pkg::F_HEAD1;
            end
            default: begin
               state_in = scfr_pkg::F_HEAD1;
            end
         endcase
      end
   end

   // datapath, store writes and command pushes
   always_comb begin
      idx_in   = idx_ff;
      plen_in  = plen_ff;
      sum_in   = sum_ff;
      good_in  = good_ff;
      lerr_in  = lerr_ff;
      serr_in  = serr_ff;
      ram_wr   = '0;
      push     = 1'b0;
      push_cmd = '0;
      if (accept) begin
         case (state_ff)
            scfr_pkg::F_HEAD1: begin
               if (rx == first_hdr_ff) begin
                  sum_in = rx;
               end
            end
            scfr_pkg::F_HEAD2: begin
               if (rx == second_hdr_ff) begin
                  sum_in = sum_ff + rx;
               end else begin
                  idx_in = '0;
               end
            end
            scfr_pkg::F_LEN: begin
               if (len_bad) begin
                  lerr_in         = lerr_ff + 1'b1;
                  idx_in          = '0;
                  push            = 1'b1;
                  push_cmd.status = scfr_pkg::STATUS_LEN_ERR;
               end else begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = '0;
                  ram_wr.data = rx;
                  idx_in      = scfr_pkg::CNT_W'(1);
                  plen_in     = rx[scfr_pkg::IDX_W-1:0];
                  sum_in      = sum_ff + rx;
               end
            end
            scfr_pkg::F_PAYLOAD: begin
               if (store_full) begin
                  lerr_in         = lerr_ff + 1'b1;
                  idx_in          = '0;
                  push            = 1'b1;
                  push_cmd.status = scfr_pkg::STATUS_LEN_ERR;
               end else begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = idx_ff[scfr_pkg::IDX_W-1:0];
                  ram_wr.data = rx;
                  idx_in      = idx_ff + 1'b1;
                  sum_in      = sum_ff + rx;
               end
            end
            scfr_pkg::F_CHECK: begin
               push   = 1'b1;
               idx_in = '0;
               if (rx == sum_ff) begin
                  good_in         = good_ff + 1'b1;
                  push_cmd.status = scfr_pkg::STATUS_FRAME;
                  push_cmd.count  = idx_ff;
               end else begin
                  serr_in         = serr_ff + 1'b1;
                  push_cmd.status = scfr_pkg::STATUS_SUM_ERR;
               end
            end
            default: begin
               idx_in = '0;
            end
         endcase
      end
      // counters as they stand after this byte
      push_cmd.good    = good_in;
      push_cmd.len_err = lerr_in;
      push_cmd.sum_err = serr_in;
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scfr_pkg::F_HEAD1;
         idx_ff   <= '0;
         plen_ff  <= '0;
         sum_ff   <= '0;
         good_ff  <= '0;
         lerr_ff  <= '0;
         serr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         plen_ff  <= plen_in;
         sum_ff   <= sum_in;
         good_ff  <= good_in;
         lerr_ff  <= lerr_in;
         serr_ff  <= serr_in;
      end
   end

   // header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_hdr_ff  <= scfr_pkg::FIRST_HEADER_RESET;
         second_hdr_ff <= scfr_pkg::SECOND_HEADER_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            scfr_pkg::CSR_FIRST_HEADER: begin
               first_hdr_ff <= csr_chan.data;
            end
            scfr_pkg::CSR_SECOND_HEADER: begin
               second_hdr_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: src/scfr_cmd_queue.sv
// short command queue between the front and back parts
// depends on scfr_pkg
`default_nettype none

module scfr_cmd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire scfr_pkg::cmd_type      push_cmd,
   input  wire logic                   pop,
   output scfr_pkg::cmd_type           head,
   output scfr_pkg::queue_status_type  status
);

   scfr_pkg::cmd_type                  entry_ff [scfr_pkg::QUEUE_DEPTH];
   logic [scfr_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [scfr_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [scfr_pkg::QUEUE_CNT_W-1:0]   fill_ff, fill_in;
   logic                               do_push;
   logic                               do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == scfr_pkg::QUEUE_CNT_W'(scfr_pkg::QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == scfr_pkg::QUEUE_PTR_W'(scfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == scfr_pkg::QUEUE_PTR_W'(scfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: src/scfr_back.sv
// back part: replays a verified frame from the store or sends an error status
// depends on scfr_pkg and scfr_if; reads the frame store, drives the result register
`default_nettype none

module scfr_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire scfr_pkg::cmd_type           head,
   input  wire scfr_pkg::queue_status_type  q_status,
   output logic                             pop,
   output logic                             busy,
   output scfr_pkg::ram_read_type           ram_rd,
   input  wire logic [scfr_pkg::BYTE_W-1:0] rd_data,
   scfr_rsp_if.source                       rsp_chan
);

   scfr_pkg::back_state_type     state_ff, state_in;
   scfr_pkg::cmd_type            cmd_ff;
   logic [scfr_pkg::CNT_W-1:0]   idx_ff;

   logic                          rsp_valid_ff;
   logic [scfr_pkg::BYTE_W-1:0]   byte_ff;
   logic                          last_ff;
   logic [scfr_pkg::STATUS_W-1:0] status_ff;
   logic [scfr_pkg::CTR_W-1:0]    good_ff;
   logic [scfr_pkg::CTR_W-1:0]    lerr_ff;
   logic [scfr_pkg::CTR_W-1:0]    serr_ff;

   logic out_free;
   logic is_last;
   logic load_data;
   logic load_err;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_last  = (scfr_pkg::CNT_W'(idx_ff + 1'b1) == cmd_ff.count);
   assign busy     = (state_ff != scfr_pkg::B_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scfr_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               state_in = (head.status == scfr_pkg::STATUS_FRAME) ?
                          scfr_pkg::B_READ : scfr_pkg::B_ERROR;
            end
         end
         scfr_pkg::B_READ: begin
            state_in = scfr_pkg::B_LOAD;
         end
         scfr_pkg::B_LOAD: begin
            if (out_free) begin
               state_in = is_last ? scfr_pkg::B_IDLE : scfr_pkg::B_READ;
            end
         end
         scfr_pkg::B_ERROR: begin
            if (out_free) begin
               state_in = scfr_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = scfr_pkg::B_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop         = 1'b0;
      ram_rd.en   = 1'b0;
      ram_rd.addr = idx_ff[scfr_pkg::IDX_W-1:0];
      load_data   = 1'b0;
      load_err    = 1'b0;
      case (state_ff)
         scfr_pkg::B_IDLE: begin
            pop = !q_status.empty;
         end
         scfr_pkg::B_READ: begin
            ram_rd.en = 1'b1;
         end
         scfr_pkg::B_LOAD: begin
            load_data = out_free;
         end
         scfr_pkg::B_ERROR: begin
            load_err = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scfr_pkg::B_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            idx_ff <= '0;
         end else if (load_data) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (load_data || load_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
      end
      if (load_data) begin
         byte_ff   <= rd_data;
         last_ff   <= is_last;
         status_ff <= scfr_pkg::STATUS_FRAME;
      end else if (load_err) begin
         byte_ff   <= '0;
         last_ff   <= 1'b1;
         status_ff <= cmd_ff.status;
      end
      if (load_data || load_err) begin
         good_ff <= cmd_ff.good;
         lerr_ff <= cmd_ff.len_err;
         serr_ff <= cmd_ff.sum_err;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.frame_byte      = byte_ff;
   assign rsp_chan.last_of_frame   = last_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.good_frames     = good_ff;
   assign rsp_chan.length_errors   = lerr_ff;
   assign rsp_chan.checksum_errors = serr_ff;

endmodule

`default_nettype wire
